@@ rtl/byte_stream_ring_with_stats_defines.svh @@
// Assertion macros shared by the byte stream ring modules.
`ifndef BYTE_STREAM_RING_WITH_STATS_DEFINES_SVH
`define BYTE_STREAM_RING_WITH_STATS_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define BSR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next cycle.
`define BSR_ASSERT_NEXT(lbl, cond, nxt, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) else $error(msg);
`else
`define BSR_ASSERT(lbl, prop, msg)
`define BSR_ASSERT_NEXT(lbl, cond, nxt, msg)
`endif

`endif

@@ rtl/bsr_pkg.sv @@
// Shared types and codes for the byte stream ring.
`timescale 1ns / 1ps
`default_nettype none
package bsr_pkg;

   localparam int ACT_W    = 3;
   localparam int BYTE_W   = 8;
   localparam int OFFS_W   = 12;
   localparam int STAT_W   = 3;
   localparam int FILL_W   = 13;
   localparam int CAP_W    = 13;
   localparam int GRACE_W  = 16;
   localparam int ELAPS_W  = 17;
   localparam int CNT_W    = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // action / operation codes
   localparam logic [ACT_W-1:0] OP_WRITE    = 3'd0;
   localparam logic [ACT_W-1:0] OP_RD_WAIT  = 3'd1;
   localparam logic [ACT_W-1:0] OP_RD_NOWT  = 3'd2;
   localparam logic [ACT_W-1:0] OP_PEEK     = 3'd3;
   localparam logic [ACT_W-1:0] OP_TICK     = 3'd4;
   localparam logic [ACT_W-1:0] OP_SET_EOF  = 3'd5;
   localparam logic [ACT_W-1:0] OP_SOFT_RST = 3'd6;
   localparam logic [ACT_W-1:0] OP_NONE     = 3'd7;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STAT_W-1:0] STAT_DROPPED = 3'd1;
   localparam logic [STAT_W-1:0] STAT_NONE    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_WOULD   = 3'd3;
   localparam logic [STAT_W-1:0] STAT_EOS     = 3'd4;
   localparam logic [STAT_W-1:0] STAT_ABORTED = 3'd5;
   localparam logic [STAT_W-1:0] STAT_TIMEOUT = 3'd6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRACE    = 1'd1;

   typedef struct packed {
      logic [ACT_W-1:0]  op;
      logic [BYTE_W-1:0] data_byte;
      logic [OFFS_W-1:0] peek_offset;
      logic              call_start;
      logic              abort_request;
   } cmd_type;

endpackage
`default_nettype wire

@@ rtl/bsr_modulo.sv @@
// Bit-serial remainder unit for peek positions that wrap more than once.
`timescale 1ns / 1ps
`default_nettype none
module bsr_modulo #(
   parameter int DW = 13
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DW-1:0]             dividend,
   input  logic [bsr_pkg::CAP_W-1:0] divisor,
   output logic                      done,
   output logic [bsr_pkg::CAP_W-1:0] remainder
);
   import bsr_pkg::*;

   localparam int CNTW = $clog2(DW + 1);

   logic [DW-1:0]    dvd_ff, dvd_in;
   logic [CAP_W-1:0] div_ff, div_in;
   logic [CAP_W-1:0] rem_ff, rem_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CAP_W:0]   trial;

   always_comb begin
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[DW-1]};
      if (start) begin
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         cnt_in  = CNTW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one restoring step per cycle, MSB first
         if (trial >= {1'b0, div_ff}) begin
            rem_in = CAP_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[CAP_W-1:0];
         end
         dvd_in = {dvd_ff[DW-2:0], 1'b0};
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

@@ rtl/bsr_front.sv @@
// Front end: accepts request transfers, classifies them, and queues commands.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_stream_ring_with_stats_defines.svh"
module bsr_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [bsr_pkg::ACT_W-1:0]  req_action,
   input  logic [bsr_pkg::BYTE_W-1:0] req_data_byte,
   input  logic [bsr_pkg::OFFS_W-1:0] req_peek_offset,
   input  logic                       req_call_start,
   input  logic                       req_abort_request,
   output bsr_pkg::cmd_type           cmd,
   output logic                       cmd_valid,
   input  logic                       cmd_pop
);
   import bsr_pkg::*;

   cmd_type     queue_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   cmd_type     cls;

   // decode: only the fields that the operation uses are kept
   always_comb begin
      cls               = '0;
      cls.op            = OP_NONE;
      case (req_action)
         OP_WRITE: begin
            cls.op        = OP_WRITE;
            cls.data_byte = req_data_byte;
         end
         OP_RD_WAIT: begin
            cls.op            = OP_RD_WAIT;
            cls.call_start    = req_call_start;
            cls.abort_request = req_abort_request;
         end
         OP_RD_NOWT:  cls.op = OP_RD_NOWT;
         OP_PEEK: begin
            cls.op          = OP_PEEK;
            cls.peek_offset = req_peek_offset;
         end
         OP_TICK:     cls.op = OP_TICK;
         OP_SET_EOF:  cls.op = OP_SET_EOF;
         OP_SOFT_RST: cls.op = OP_SOFT_RST;
         default:     cls.op = OP_NONE;
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

   `BSR_ASSERT(a_count_bound, count_ff <= 2'd2, "command queue count out of range")
   `BSR_ASSERT(a_pop_nonempty, !cmd_pop || count_ff != 2'd0, "pop from empty command queue")
   `BSR_ASSERT_NEXT(a_push_visible, push && count_ff == 2'd0, cmd_valid, "pushed command lost")

endmodule
`default_nettype wire

@@ rtl/bsr_back.sv @@
// Back end: ring memory, pointers, statistics and the response register.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_stream_ring_with_stats_defines.svh"
module bsr_back #(
   parameter int DEPTH = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bsr_pkg::cmd_type            cmd,
   input  logic                        cmd_valid,
   output logic                        cmd_pop,
   input  logic [bsr_pkg::CAP_W-1:0]   eff_cap,
   input  logic [bsr_pkg::GRACE_W-1:0] grace,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bsr_pkg::BYTE_W-1:0]  rsp_data_out,
   output logic [bsr_pkg::STAT_W-1:0]  rsp_status,
   output logic [bsr_pkg::FILL_W-1:0]  rsp_fill_level,
   output logic [bsr_pkg::CNT_W-1:0]   rsp_underrun_count,
   output logic [bsr_pkg::FILL_W-1:0]  rsp_min_fill,
   output logic [bsr_pkg::CNT_W-1:0]   rsp_bytes_in
);
   import bsr_pkg::*;

   localparam int AW  = $clog2(DEPTH);
   localparam int SW  = $clog2(DEPTH + 4096);
   localparam int CW0 = (SW > AW + 1) ? SW : AW + 1;
   localparam int CW  = (CW0 > CAP_W + 1) ? CW0 : CAP_W + 1;
   localparam int FILL_MAX_I = (DEPTH < 8191) ? DEPTH : 8191;
   localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(FILL_MAX_I);
   localparam logic [FILL_W-1:0] LOW_RESET = FILL_W'((DEPTH < 4096) ? DEPTH : 4096);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MOD   = 2'd1;
   localparam logic [1:0] S_RDATA = 2'd2;

   logic [BYTE_W-1:0] ring_mem [DEPTH];
   logic [BYTE_W-1:0] mem_q_ff;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_raddr;

   logic [1:0]         state_ff, state_in;
   logic [AW-1:0]      widx_ff, widx_in;
   logic [AW-1:0]      ridx_ff, ridx_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               eof_ff, eof_in;
   logic               wait_ff, wait_in;
   logic [ELAPS_W-1:0] elapsed_ff, elapsed_in;
   logic [CNT_W-1:0]   under_ff, under_in;
   logic [FILL_W-1:0]  low_ff, low_in;
   logic [CNT_W-1:0]   bytes_ff, bytes_in;

   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_data_ff;
   logic [STAT_W-1:0]  out_status_ff;
   logic [FILL_W-1:0]  out_fill_ff;
   logic [CNT_W-1:0]   out_under_ff;
   logic [FILL_W-1:0]  out_low_ff;
   logic [CNT_W-1:0]   out_bytes_ff;

   logic               out_free, load_now, load_mem;
   logic [STAT_W-1:0]  load_status;
   logic [SW-1:0]      peek_sum;
   logic [CW-1:0]      sum_c, cap_c;
   logic               mod_start, mod_done;
   logic [CAP_W-1:0]   mod_rem;

   function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                             input logic [CAP_W-1:0] cap);
      logic [CW-1:0] nx;
      nx = CW'(idx) + CW'(1);
      if (nx >= CW'(cap) || nx >= CW'(DEPTH)) begin
         return '0;
      end
      return AW'(nx);
   endfunction

   bsr_modulo #(.DW(SW)) u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (peek_sum),
      .divisor   (eff_cap),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign out_free = !out_valid_ff || !rsp_stall;
   assign peek_sum = SW'(ridx_ff) + SW'(cmd.peek_offset);
   assign sum_c    = CW'(peek_sum);
   assign cap_c    = CW'(eff_cap);

   always_comb begin
      state_in    = state_ff;
      widx_in     = widx_ff;
      ridx_in     = ridx_ff;
      fill_in     = fill_ff;
      eof_in      = eof_ff;
      wait_in     = wait_ff;
      elapsed_in  = elapsed_ff;
      under_in    = under_ff;
      low_in      = low_ff;
      bytes_in    = bytes_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_raddr   = ridx_ff;
      mod_start   = 1'b0;
      cmd_pop     = 1'b0;
      load_now    = 1'b0;
      load_mem    = 1'b0;
      load_status = STAT_OK;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop  = 1'b1;
               load_now = 1'b1;
               case (cmd.op)
                  OP_WRITE: begin
                     if (fill_ff >= eff_cap) begin
                        load_status = STAT_DROPPED;
                     end else begin
                        mem_we   = 1'b1;
                        widx_in  = advance(widx_ff, eff_cap);
                        fill_in  = fill_ff + FILL_W'(1);
                        bytes_in = bytes_ff + CNT_W'(1);
                     end
                  end
                  OP_RD_WAIT: begin
                     if (cmd.call_start) begin
                        wait_in    = 1'b0;
                        elapsed_in = '0;
                     end
                     if (fill_ff != '0) begin
                        if (wait_in) begin
                           if (under_ff != '1) begin
                              under_in = under_ff + CNT_W'(1);
                           end
                           wait_in = 1'b0;
                        end
                        if (fill_ff < low_ff) begin
                           low_in = fill_ff;
                        end
                        load_now   = 1'b0;
                        mem_re     = 1'b1;
                        ridx_in    = advance(ridx_ff, eff_cap);
                        fill_in    = fill_ff - FILL_W'(1);
                        elapsed_in = '0;
                        state_in   = S_RDATA;
                     end else if (eof_ff) begin
                        load_status = STAT_EOS;
                     end else if (cmd.abort_request) begin
                        load_status = STAT_ABORTED;
                     end else if (elapsed_in > ELAPS_W'(grace)) begin
                        load_status = STAT_TIMEOUT;
                     end else begin
                        load_status = STAT_WOULD;
                        wait_in     = 1'b1;
                     end
                  end
                  OP_RD_NOWT: begin
                     if (fill_ff != '0) begin
                        load_now = 1'b0;
                        mem_re   = 1'b1;
                        ridx_in  = advance(ridx_ff, eff_cap);
                        fill_in  = fill_ff - FILL_W'(1);
                        state_in = S_RDATA;
                     end else begin
                        load_status = STAT_NONE;
                     end
                  end
                  OP_PEEK: begin
                     if ({1'b0, cmd.peek_offset} < fill_ff) begin
                        load_now = 1'b0;
                        if (sum_c < cap_c) begin
                           mem_re    = 1'b1;
                           mem_raddr = AW'(peek_sum);
                           state_in  = S_RDATA;
                        end else if (sum_c < (cap_c << 1)) begin
                           mem_re    = 1'b1;
                           mem_raddr = AW'(sum_c - cap_c);
                           state_in  = S_RDATA;
                        end else begin
                           // peek position at or beyond twice a shrunk capacity
                           mod_start = 1'b1;
                           state_in  = S_MOD;
                        end
                     end else begin
                        load_status = STAT_NONE;
                     end
                  end
                  OP_TICK: begin
                     if (elapsed_ff != '1) begin
                        elapsed_in = elapsed_ff + ELAPS_W'(1);
                     end
                  end
                  OP_SET_EOF: begin
                     eof_in = 1'b1;
                  end
                  OP_SOFT_RST: begin
                     widx_in    = '0;
                     ridx_in    = '0;
                     fill_in    = '0;
                     eof_in     = 1'b0;
                     wait_in    = 1'b0;
                     elapsed_in = '0;
                     under_in   = '0;
                     bytes_in   = '0;
                     low_in     = eff_cap;
                  end
                  default: begin
                     load_status = STAT_NONE;
                  end
               endcase
            end
         end
         S_MOD: begin
            if (mod_done) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(mod_rem);
               state_in  = S_RDATA;
            end
         end
         S_RDATA: begin
            load_mem = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_now || load_mem) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[widx_ff] <= cmd.data_byte;
      end
      if (mem_re) begin
         mem_q_ff <= ring_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         widx_ff      <= '0;
         ridx_ff      <= '0;
         fill_ff      <= '0;
         eof_ff       <= 1'b0;
         wait_ff      <= 1'b0;
         elapsed_ff   <= '0;
         under_ff     <= '0;
         low_ff       <= LOW_RESET;
         bytes_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         widx_ff      <= widx_in;
         ridx_ff      <= ridx_in;
         fill_ff      <= fill_in;
         eof_ff       <= eof_in;
         wait_ff      <= wait_in;
         elapsed_ff   <= elapsed_in;
         under_ff     <= under_in;
         low_ff       <= low_in;
         bytes_ff     <= bytes_in;
         out_valid_ff <= out_valid_in;
      end
      if (load_now) begin
         out_data_ff   <= '0;
         out_status_ff <= load_status;
         out_fill_ff   <= fill_in;
         out_under_ff  <= under_in;
         out_low_ff    <= low_in;
         out_bytes_ff  <= bytes_in;
      end else if (load_mem) begin
         // state was already updated at dispatch
         out_data_ff   <= mem_q_ff;
         out_status_ff <= STAT_OK;
         out_fill_ff   <= fill_ff;
         out_under_ff  <= under_ff;
         out_low_ff    <= low_ff;
         out_bytes_ff  <= bytes_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_data_out       = out_data_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_fill_level     = out_fill_ff;
   assign rsp_underrun_count = out_under_ff;
   assign rsp_min_fill       = out_low_ff;
   assign rsp_bytes_in       = out_bytes_ff;

   `BSR_ASSERT(a_fill_bound, fill_ff <= FILL_MAX, "fill count above ring size")
   `BSR_ASSERT(a_rdata_free, state_ff != S_RDATA || !out_valid_ff, "response register busy on read")
   `BSR_ASSERT(a_pop_idle, !cmd_pop || (state_ff == S_IDLE && cmd_valid), "command taken while busy")
   `BSR_ASSERT_NEXT(a_mem_op_load, mem_re && state_ff == S_IDLE, state_ff == S_RDATA && !out_valid_ff, "memory read not followed by load")

endmodule
`default_nettype wire

@@ rtl/byte_stream_ring_with_stats.sv @@
// Top level of the byte stream ring with underrun statistics.
`timescale 1ns / 1ps
`default_nettype none
// Byte ring FIFO for an audio stream. Each request transfer carries one
// action (write, waiting read, non-waiting read, peek, tick, set end of
// stream, soft reset) and yields exactly one response transfer with the byte
// read, a status code and a snapshot of fill, underrun count, minimum fill
// and bytes accepted. A two-entry command queue sits between the request
// port and the execution unit, and the response is held in an output
// register, so a new request is taken while a response waits. Writes,
// ticks, set-eof, soft reset, unused codes and reads or peeks that return
// no byte load the response register at dispatch in the execution unit;
// reads and peeks that return a byte pass through a read-data state first
// because the ring is a synchronous memory with a registered read port. A
// peek whose position wraps more than once (only possible after capacity
// was lowered) runs a bit-serial remainder before its memory read. The ring
// contents come up undefined and need no clearing pass; pointers and
// statistics reset at once. Capacity 0 acts as 1 and values above DEPTH act
// as DEPTH. Register writes are only valid while no transfer is in flight.
module byte_stream_ring_with_stats #(
   parameter int DEPTH = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bsr_pkg::ACT_W-1:0]      req_action,
   input  logic [bsr_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic [bsr_pkg::OFFS_W-1:0]     req_peek_offset,
   input  logic                           req_call_start,
   input  logic                           req_abort_request,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bsr_pkg::BYTE_W-1:0]     rsp_data_out,
   output logic [bsr_pkg::STAT_W-1:0]     rsp_status,
   output logic [bsr_pkg::FILL_W-1:0]     rsp_fill_level,
   output logic [bsr_pkg::CNT_W-1:0]      rsp_underrun_count,
   output logic [bsr_pkg::FILL_W-1:0]     rsp_min_fill,
   output logic [bsr_pkg::CNT_W-1:0]      rsp_bytes_in,
   input  logic                           csr_write,
   input  logic [bsr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bsr_pkg::CSR_DATA_W-1:0] csr_data
);
   import bsr_pkg::*;

   logic [CAP_W-1:0]   cap_ff;
   logic [GRACE_W-1:0] grace_ff;
   logic [CAP_W-1:0]   eff_cap;
   cmd_type            cmd;
   logic               cmd_valid;
   logic               cmd_pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_W'(4096);
         grace_ff <= GRACE_W'(1000);
      end else if (csr_write) begin
         case (csr_index)
            CSR_CAPACITY: cap_ff   <= csr_data[CAP_W-1:0];
            CSR_GRACE:    grace_ff <= csr_data;
            default:      ;
         endcase
      end
   end

   // clamp capacity into 1..DEPTH
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CAP_W'(1);
      end else if (32'(cap_ff) > 32'(DEPTH)) begin
         eff_cap = CAP_W'(DEPTH);
      end else begin
         eff_cap = cap_ff;
      end
   end

   bsr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_data_byte     (req_data_byte),
      .req_peek_offset   (req_peek_offset),
      .req_call_start    (req_call_start),
      .req_abort_request (req_abort_request),
      .cmd               (cmd),
      .cmd_valid         (cmd_valid),
      .cmd_pop           (cmd_pop)
   );

   bsr_back #(.DEPTH(DEPTH)) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cmd_valid          (cmd_valid),
      .cmd_pop            (cmd_pop),
      .eff_cap            (eff_cap),
      .grace              (grace_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_out       (rsp_data_out),
      .rsp_status         (rsp_status),
      .rsp_fill_level     (rsp_fill_level),
      .rsp_underrun_count (rsp_underrun_count),
      .rsp_min_fill       (rsp_min_fill),
      .rsp_bytes_in       (rsp_bytes_in)
   );

endmodule
`default_nettype wire
